@@ sv/fud_pkg.sv @@
`default_nettype none

package fud_pkg;

   // Characters with a meaning of their own in a form body.
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Most results that one input byte can cause.
   localparam int MAX_RESULTS = 3;

   // One result beat.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       is_value;
      logic       pair_end;
      logic       pair_ok;
      logic       run_last;
   } rsp_type;

   // All results of one input byte, in order, with their number.
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] item;
      logic [1:0]                count;
   } bundle_type;

   // Status of the result serialiser seen by the top level.
   typedef struct packed {
      logic       free;
      logic [1:0] remaining;
   } ser_stat_type;

   // Hex digit value: bit 4 set when the byte is a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // In a value, '+' stands for a space.
   function automatic logic [7:0] plus_to_space(input logic [7:0] c);
      return (c == CHAR_PLUS) ? CHAR_SPACE : c;
   endfunction

endpackage

`default_nettype wire

@@ sv/fud_req_if.sv @@
`default_nettype none

interface fud_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

`default_nettype wire

@@ sv/fud_rsp_if.sv @@
`default_nettype none

interface fud_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       is_value;
   logic       pair_end;
   logic       pair_ok;
   logic       run_last;

   modport source (output valid, output out_byte, output has_byte, output is_value,
                   output pair_end, output pair_ok, output run_last, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input is_value,
                   input pair_end, input pair_ok, input run_last, output ready);
endinterface

`default_nettype wire

@@ sv/fud_decode.sv @@
`default_nettype none

module fud_decode (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic [7:0]          in_byte,
   input  wire logic                in_last,
   output fud_pkg::bundle_type      bundle
);

   // Escape phase codes.
   localparam logic [1:0] PH_NONE = 2'd0;
   localparam logic [1:0] PH_PCT  = 2'd1;
   localparam logic [1:0] PH_HELD = 2'd2;

   logic       in_value_ff, in_value_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;

   logic       amp;
   logic       close;
   logic [7:0] pb;
   logic [4:0] h1, h2;
   logic [7:0] esc_val;
   logic [1:0] nb;
   logic [7:0] b0, b1;

   // Work out the bytes of this beat and the next state of the segment.
   always_comb begin
      amp         = (in_byte == fud_pkg::CHAR_AMP);
      close       = amp || in_last;
      pb          = fud_pkg::plus_to_space(in_byte);
      h1          = fud_pkg::hex_digit(held_ff);
      h2          = fud_pkg::hex_digit(pb);
      in_value_in = in_value_ff;
      phase_in    = phase_ff;
      held_in     = held_ff;
      nb          = 2'd0;
      b0          = 8'd0;
      b1          = 8'd0;

      // Two hex digits give both nibbles, one gives its value, none gives zero.
      if (!h1[4]) begin
         esc_val = 8'd0;
      end else if (!h2[4]) begin
         esc_val = {4'd0, h1[3:0]};
      end else begin
         esc_val = {h1[3:0], h2[3:0]};
      end

      if (!in_value_ff) begin
         if (!amp) begin
            if (in_byte == fud_pkg::CHAR_EQ) begin
               in_value_in = 1'b1;
            end else begin
               nb = 2'd1;
               b0 = in_byte;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_PCT: begin
               if (amp) begin
                  nb = 2'd1;
                  b0 = fud_pkg::CHAR_PCT;
               end else if (in_last) begin
                  nb = 2'd2;
                  b0 = fud_pkg::CHAR_PCT;
                  b1 = pb;
               end else begin
                  held_in  = pb;
                  phase_in = PH_HELD;
               end
            end
            PH_HELD: begin
               if (amp) begin
                  nb = 2'd2;
                  b0 = fud_pkg::CHAR_PCT;
                  b1 = held_ff;
               end else begin
                  nb       = 2'd1;
                  b0       = esc_val;
                  phase_in = PH_NONE;
                  held_in  = 8'd0;
               end
            end
            default: begin
               // No escape pending; the unused phase code behaves the same.
               if (!amp) begin
                  if (in_byte == fud_pkg::CHAR_PCT && !in_last) begin
                     phase_in = PH_PCT;
                  end else begin
                     nb = 2'd1;
                     b0 = (in_byte == fud_pkg::CHAR_PCT) ? fud_pkg::CHAR_PCT : pb;
                  end
               end
            end
         endcase
      end
   end

   // Lay the results out in order, pair end after the bytes.
   always_comb begin
      bundle = '0;
      if (nb != 2'd0) begin
         bundle.item[0].out_byte = b0;
         bundle.item[0].has_byte = 1'b1;
         bundle.item[0].is_value = in_value_ff;
      end
      if (nb == 2'd2) begin
         bundle.item[1].out_byte = b1;
         bundle.item[1].has_byte = 1'b1;
         bundle.item[1].is_value = in_value_ff;
      end
      if (close) begin
         bundle.item[nb].pair_end = 1'b1;
         bundle.item[nb].pair_ok  = in_value_in;
      end
      bundle.count = nb + {1'b0, close};
      if (bundle.count != 2'd0) begin
         bundle.item[bundle.count - 2'd1].run_last = 1'b1;
      end
   end

   // Segment state; a closed segment starts again from the key phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_value_ff <= 1'b0;
         phase_ff    <= PH_NONE;
         held_ff     <= 8'd0;
      end else if (advance) begin
         if (close) begin
            in_value_ff <= 1'b0;
            phase_ff    <= PH_NONE;
            held_ff     <= 8'd0;
         end else begin
            in_value_ff <= in_value_in;
            phase_ff    <= phase_in;
            held_ff     <= held_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/fud_serialiser.sv @@
`default_nettype none

module fud_serialiser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire fud_pkg::bundle_type   bundle,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output fud_pkg::rsp_type           rsp_item,
   output fud_pkg::ser_stat_type      stat
);

   fud_pkg::rsp_type [fud_pkg::MAX_RESULTS-1:0] items_ff;
   logic [1:0] remaining_ff;
   logic [1:0] idx_ff;
   logic       beat;

   // Present the current result and report when the register can take more.
   always_comb begin
      rsp_valid      = (remaining_ff != 2'd0);
      rsp_item       = items_ff[idx_ff];
      beat           = rsp_valid && rsp_ready;
      stat.remaining = remaining_ff;
      stat.free      = (remaining_ff == 2'd0) || (remaining_ff == 2'd1 && rsp_ready);
   end

   // Count the results of the held byte out one beat at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 2'd0;
         idx_ff       <= 2'd0;
      end else if (load) begin
         remaining_ff <= bundle.count;
         idx_ff       <= 2'd0;
      end else if (beat) begin
         remaining_ff <= remaining_ff - 2'd1;
         idx_ff       <= idx_ff + 2'd1;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         items_ff <= bundle.item;
      end
   end

endmodule

`default_nettype wire

@@ sv/form_urlencoded_decoder.sv @@
// Path: an accepted byte waits in the input register until its results load the
// result register. Throughput: one byte per cycle while each byte causes at most
// one result and the receiver is ready; a byte with two or three results (cut-off
// escape, segment end) holds the result register and the input for that many beats.
// Reset: synchronous and active high; it empties both registers and returns the
// decoder to the key phase with no escape pending.
`default_nettype none

module form_urlencoded_decoder (
   input  wire logic    clock,
   input  wire logic    reset,
   fud_req_if.sink      req_chan,
   fud_rsp_if.source    rsp_chan
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;

   fud_pkg::bundle_type   bundle;
   fud_pkg::rsp_type      rsp_item;
   fud_pkg::ser_stat_type ser_stat;
   logic                  rsp_valid;

   // A held byte moves on once the result register is free.
   assign advance        = in_valid_ff && ser_stat.free;
   assign req_chan.ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.in_byte;
         in_last_ff <= req_chan.is_last;
      end
   end

   fud_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .bundle  (bundle)
   );

   fud_serialiser u_serialiser (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .bundle    (bundle),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .stat      (ser_stat)
   );

   // Result channel.
   assign rsp_chan.valid    = rsp_valid;
   assign rsp_chan.out_byte = rsp_item.out_byte;
   assign rsp_chan.has_byte = rsp_item.has_byte;
   assign rsp_chan.is_value = rsp_item.is_value;
   assign rsp_chan.pair_end = rsp_item.pair_end;
   assign rsp_chan.pair_ok  = rsp_item.pair_ok;
   assign rsp_chan.run_last = rsp_item.run_last;

`ifndef SYNTHESIS
   // The last result of a byte is exactly the last one held in the register.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.run_last == (ser_stat.remaining == 2'd1)))
      else $error("run_last does not match the last held result");

   // A byte waiting on a busy result register blocks the input.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !ser_stat.free) |-> !req_chan.ready)
      else $error("input taken while the held byte is stuck");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result offered straight after reset");
`endif

endmodule

`default_nettype wire

@@ sim/tb_form_urlencoded_decoder.sv @@
`default_nettype none

module tb_form_urlencoded_decoder;

   // Escape progress inside a value.
   typedef enum logic [1:0] {
      ESC_NONE        = 2'd0,
      ESC_AFTER_PCT   = 2'd1,
      ESC_AFTER_FIRST = 2'd2
   } esc_state_type;

   // One byte of a form body waiting to be sent, with its idle gap before it.
   typedef struct {
      logic [7:0] data;
      logic       last;
      int         gap;
      logic       drain;
   } form_byte_type;

   // Length of the receiver's hold-off, counted down once the gapless burst starts.
   localparam int HOLD_CYCLES = 60;

   logic clock;
   logic reset;

   fud_req_if req_chan ();
   fud_rsp_if rsp_chan ();

   form_urlencoded_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Bytes still to be sent and decoded beats still to arrive.
   form_byte_type    body_bytes[$];
   fud_pkg::rsp_type decoded_beats[$];

   // Decoder state as the testbench sees it.
   logic          seg_in_value;
   esc_state_type esc_state;
   logic [7:0]    esc_first;

   // Progress counters, updated with nonblocking assignments so that every
   // reader at a clock edge sees the value from before that edge.
   int bytes_sent      = 0;
   int beats_predicted = 0;
   int beats_checked   = 0;

   int error_count     = 0;
   int pairs_kept      = 0;
   int pairs_dropped   = 0;
   int escapes_decoded = 0;
   int bodies_built    = 0;
   int total_bytes     = 0;
   int directed_bytes  = 0;
   int calm_start      = 0;
   int hold_left       = 0;

   logic sender_calm  = 1'b0;
   logic hold_results = 1'b0;
   logic hold_done    = 1'b0;

   // The clock runs from time zero.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reset is held high from time zero, then released.
   initial begin : apply_reset
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // In a value, '+' stands for a space.
   function automatic logic [7:0] space_for_plus(input logic [7:0] c);
      if (c == fud_pkg::CHAR_PLUS) begin
         return fud_pkg::CHAR_SPACE;
      end
      return c;
   endfunction

   // Value of a hex digit, or -1 when the byte is not one.
   function automatic int nibble_of(input logic [7:0] c);
      logic [7:0] zero_char;
      logic [7:0] lower_a;
      logic [7:0] upper_a;
      zero_char = "0";
      lower_a   = "a";
      upper_a   = "A";
      if (c >= zero_char && c <= zero_char + 8'd9) begin
         return int'(c - zero_char);
      end
      if (c >= lower_a && c <= lower_a + 8'd5) begin
         return int'(c - lower_a) + 10;
      end
      if (c >= upper_a && c <= upper_a + 8'd5) begin
         return int'(c - upper_a) + 10;
      end
      return -1;
   endfunction

   function automatic fud_pkg::rsp_type byte_beat(input logic [7:0] b,
                                                  input logic value_side);
      fud_pkg::rsp_type beat;
      beat          = '0;
      beat.out_byte = b;
      beat.has_byte = 1'b1;
      beat.is_value = value_side;
      return beat;
   endfunction

   // Work out the beats that one accepted byte causes and queue them.
   task automatic predict_beats(input logic [7:0] data, input logic last, output int n);
      fud_pkg::rsp_type run[$];
      fud_pkg::rsp_type close_beat;
      logic             is_amp;
      int               hi;
      int               lo;
      logic [7:0]       decoded;
      is_amp = (data == fud_pkg::CHAR_AMP);
      if (!seg_in_value) begin
         // Key bytes pass raw up to the first '='.
         if (!is_amp) begin
            if (data == fud_pkg::CHAR_EQ) begin
               seg_in_value = 1'b1;
            end else begin
               run = {run, byte_beat(data, 1'b0)};
            end
         end
      end else begin
         case (esc_state)
            ESC_AFTER_PCT: begin
               // A segment end right after '%' lets the held bytes out literally.
               if (is_amp) begin
                  run = {run, byte_beat(fud_pkg::CHAR_PCT, 1'b1)};
               end else if (last) begin
                  run = {run, byte_beat(fud_pkg::CHAR_PCT, 1'b1)};
                  run = {run, byte_beat(space_for_plus(data), 1'b1)};
               end else begin
                  esc_first = space_for_plus(data);
                  esc_state = ESC_AFTER_FIRST;
               end
            end
            ESC_AFTER_FIRST: begin
               if (is_amp) begin
                  run = {run, byte_beat(fud_pkg::CHAR_PCT, 1'b1)};
                  run = {run, byte_beat(esc_first, 1'b1)};
               end else begin
                  // Leading hex digits only: two, one or none.
                  hi = nibble_of(esc_first);
                  lo = nibble_of(space_for_plus(data));
                  if (hi < 0) begin
                     decoded = 8'h00;
                  end else if (lo < 0) begin
                     decoded = 8'(hi);
                  end else begin
                     decoded = 8'(hi * 16 + lo);
                  end
                  run = {run, byte_beat(decoded, 1'b1)};
                  esc_state = ESC_NONE;
                  esc_first = 8'h00;
                  escapes_decoded++;
               end
            end
            default: begin
               if (!is_amp) begin
                  if (data == fud_pkg::CHAR_PCT) begin
                     if (last) begin
                        run = {run, byte_beat(fud_pkg::CHAR_PCT, 1'b1)};
                     end else begin
                        esc_state = ESC_AFTER_PCT;
                     end
                  end else begin
                     run = {run, byte_beat(space_for_plus(data), 1'b1)};
                  end
               end
            end
         endcase
      end

      // The segment closes on '&' or on the last byte of the body.
      if (is_amp || last) begin
         close_beat          = '0;
         close_beat.pair_end = 1'b1;
         close_beat.pair_ok  = seg_in_value;
         run = {run, close_beat};
         seg_in_value = 1'b0;
         esc_state    = ESC_NONE;
         esc_first    = 8'h00;
      end

      if (run.size() > 0) begin
         run[run.size() - 1].run_last = 1'b1;
      end
      n = run.size();
      foreach (run[i]) begin
         decoded_beats = {decoded_beats, run[i]};
      end
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Stimulus building.
   task automatic add_byte(input logic [7:0] b);
      form_byte_type fb;
      fb.data  = b;
      fb.last  = 1'b0;
      fb.gap   = sender_calm ? 0 : $urandom_range(0, 11);
      fb.drain = 1'b0;
      body_bytes = {body_bytes, fb};
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i]);
      end
   endtask

   task automatic end_body();
      body_bytes[body_bytes.size() - 1].last = 1'b1;
      bodies_built++;
   endtask

   function automatic logic [7:0] random_hex_char();
      logic [7:0] base;
      case ($urandom_range(0, 2))
         0: begin
            base = "0";
            return base + 8'($urandom_range(0, 9));
         end
         1: begin
            base = "a";
            return base + 8'($urandom_range(0, 5));
         end
         default: begin
            base = "A";
            return base + 8'($urandom_range(0, 5));
         end
      endcase
   endfunction

   function automatic logic [7:0] random_key_char();
      logic [7:0] b;
      if ($urandom_range(0, 3) != 0) begin
         b = "a";
         return b + 8'($urandom_range(0, 25));
      end
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == fud_pkg::CHAR_AMP || b == fud_pkg::CHAR_EQ);
      return b;
   endfunction

   function automatic logic [7:0] random_escape_char();
      if ($urandom_range(0, 4) != 0) begin
         return random_hex_char();
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // A form body of one or more pairs, mostly well formed.
   task automatic add_form_body();
      int         n_seg;
      int         start_size;
      logic [7:0] b;
      n_seg      = $urandom_range(1, 4);
      start_size = body_bytes.size();
      for (int s = 0; s < n_seg; s++) begin
         repeat ($urandom_range(0, 3)) add_byte(random_key_char());
         if ($urandom_range(0, 7) != 0) begin
            add_byte(fud_pkg::CHAR_EQ);
            repeat ($urandom_range(0, 4)) begin
               case ($urandom_range(0, 5))
                  0: add_byte(fud_pkg::CHAR_PLUS);
                  1, 2: begin
                     add_byte(fud_pkg::CHAR_PCT);
                     add_byte(random_escape_char());
                     add_byte(random_escape_char());
                  end
                  default: begin
                     do begin
                        b = 8'($urandom_range(0, 255));
                     end while (b == fud_pkg::CHAR_AMP || b == fud_pkg::CHAR_PCT);
                     add_byte(b);
                  end
               endcase
            end
            // Now and then an escape that the segment end cuts off.
            if ($urandom_range(0, 6) == 0) begin
               add_byte(fud_pkg::CHAR_PCT);
               if ($urandom_range(0, 1) == 0) begin
                  add_byte(random_escape_char());
               end
            end
         end
         if (s < n_seg - 1) begin
            add_byte(fud_pkg::CHAR_AMP);
         end
      end
      // Empty bodies and some others end on a trailing '&'.
      if (body_bytes.size() == start_size || $urandom_range(0, 5) == 0) begin
         add_byte(fud_pkg::CHAR_AMP);
      end
      // Some bodies wait for all earlier results before they start.
      if (!sender_calm && $urandom_range(0, 5) == 0) begin
         body_bytes[start_size].drain = 1'b1;
      end
      end_body();
   endtask

   // Fill the queue: corner cases first, then random bodies with a burst
   // in the middle that is sent without gaps.
   initial begin : build_stimulus
      int drain_at;
      add_text("key=va+lue&=x&&flag&k=%4");
      end_body();
      add_text("x=%2&y=%&z=%");
      end_body();
      add_text("p=%+1%a+%G1%41%6A%zz");
      end_body();
      add_text("&");
      end_body();
      add_text("=");
      end_body();
      add_text("k=%41&");
      end_body();
      directed_bytes = body_bytes.size();

      while (body_bytes.size() < 150) begin
         add_form_body();
      end

      calm_start  = body_bytes.size();
      sender_calm = 1'b1;
      while (body_bytes.size() < calm_start + 30) begin
         add_form_body();
      end
      sender_calm = 1'b0;

      drain_at = body_bytes.size();
      add_form_body();
      body_bytes[drain_at].drain = 1'b1;

      while (body_bytes.size() < 220) begin
         add_form_body();
      end
      total_bytes = body_bytes.size();
   end

   // Driver: offers the queued bytes and predicts each accepted beat.
   always @(posedge clock) begin : drive_bytes
      int            new_beats;
      logic          stalled;
      form_byte_type next_byte;
      new_beats = 0;
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.in_byte <= 8'h00;
         req_chan.is_last <= 1'b0;
         seg_in_value     = 1'b0;
         esc_state        = ESC_NONE;
         esc_first        = 8'h00;
      end else begin
         stalled = req_chan.valid && !req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            predict_beats(req_chan.in_byte, req_chan.is_last, new_beats);
            beats_predicted <= beats_predicted + new_beats;
            bytes_sent      <= bytes_sent + 1;
         end
         if (!stalled) begin
            if (body_bytes.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else if (body_bytes[0].gap > 0) begin
               body_bytes[0].gap = body_bytes[0].gap - 1;
               req_chan.valid <= 1'b0;
            end else if (body_bytes[0].drain &&
                         beats_predicted + new_beats != beats_checked) begin
               // Pause until every result beat so far has come out.
               req_chan.valid <= 1'b0;
            end else begin
               next_byte = body_bytes.pop_front();
               req_chan.valid   <= 1'b1;
               req_chan.in_byte <= next_byte.data;
               req_chan.is_last <= next_byte.last;
            end
         end
      end
   end

   // Long hold-off of the receiver once the gapless burst starts.
   always @(posedge clock) begin : hold_receiver
      if (reset) begin
         hold_results <= 1'b0;
         hold_left    <= 0;
         hold_done    <= 1'b0;
      end else if (hold_results) begin
         if (hold_left == 0) begin
            hold_results <= 1'b0;
         end else begin
            hold_left <= hold_left - 1;
         end
      end else if (!hold_done && bytes_sent >= calm_start) begin
         hold_results <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         hold_done    <= 1'b1;
      end
   end

   // Monitor: takes result beats after a random wait and checks each one.
   always @(posedge clock) begin : take_results
      fud_pkg::rsp_type want;
      int               rsp_wait;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (decoded_beats.size() == 0) begin
               $error("result beat with none expected: out_byte 0x%0h", rsp_chan.out_byte);
               error_count++;
            end else begin
               want = decoded_beats.pop_front();
               compare_field("out_byte", want.out_byte, rsp_chan.out_byte);
               compare_field("has_byte", want.has_byte, rsp_chan.has_byte);
               compare_field("is_value", want.is_value, rsp_chan.is_value);
               compare_field("pair_end", want.pair_end, rsp_chan.pair_end);
               compare_field("pair_ok", want.pair_ok, rsp_chan.pair_ok);
               compare_field("run_last", want.run_last, rsp_chan.run_last);
            end
            if (rsp_chan.pair_end) begin
               if (rsp_chan.pair_ok) begin
                  pairs_kept++;
               end else begin
                  pairs_dropped++;
               end
            end
            beats_checked <= beats_checked + 1;
            rsp_wait = $urandom_range(0, 11);
         end
         if (hold_results) begin
            rsp_chan.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // End of run once every byte is sent and every predicted beat checked.
   initial begin : finish_run
      wait (reset === 1'b0);
      @(negedge clock);
      while (body_bytes.size() != 0 || req_chan.valid ||
             beats_checked != beats_predicted) begin
         @(negedge clock);
      end
      repeat (30) @(negedge clock);
      $display("Sent %0d bodies of %0d bytes (%0d in hand-picked corner cases), %0d escapes.",
               bodies_built, total_bytes, directed_bytes, escapes_decoded);
      $display("Checked %0d beats: %0d pairs kept, %0d dropped, with one long hold-off.",
               beats_checked, pairs_kept, pairs_dropped);
      if (error_count == 0 && decoded_beats.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Hard stop well beyond the longest correct run.
   initial begin : run_limit
      #2000000;
      $display("Run stopped by the time limit: %0d of %0d bytes sent, %0d of %0d beats.",
               bytes_sent, total_bytes, beats_checked, beats_predicted);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
